### src/circular_linked_ring_editor_macros.svh
// assertion macros for the ring editor, included by clre_ctrl
// no dependencies; included inside module bodies
`ifndef CIRCULAR_LINKED_RING_EDITOR_MACROS_SVH
`define CIRCULAR_LINKED_RING_EDITOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CLRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring editor check failed");

// next-cycle implication, disabled while reset is asserted
`define CLRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring editor check failed");

`endif

### src/clre_pkg.sv
// shared types and codes for the ring editor
// used by clre_ctrl, clre_dpath and circular_linked_ring_editor
package clre_pkg;

  localparam logic [2:0] KIND_APPEND     = 3'd0;
  localparam logic [2:0] KIND_INS_AFTER  = 3'd1;
  localparam logic [2:0] KIND_INS_BEFORE = 3'd2;
  localparam logic [2:0] KIND_REM_NEXT   = 3'd3;
  localparam logic [2:0] KIND_REM_PREV   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AP1,
    S_AP2,
    S_INS_EVAL,
    S_INS_W2,
    S_REM_EVAL,
    S_REM_WR
  } ctrl_state_t;

  // where the link memories take their read addresses
  typedef enum logic [1:0] {
    RD_INPUT,
    RD_STATION,
    RD_LINK
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_AP_SOLO,
    WR_AP_NEW,
    WR_AP_ENDS,
    WR_INS_NEW,
    WR_INS_SIDES,
    WR_REM
  } wr_op_t;

  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    wr_op_t  wr_op;
    logic    load_out;
  } clre_cmd_t;

  typedef struct packed {
    logic out_free;
    logic ring_nonempty;
  } clre_status_t;

endpackage

### src/clre_dpath.sv
// datapath of the ring editor: link memories, ring ends, output register
// depends on clre_pkg; driven by clre_ctrl
module clre_dpath #(
  parameter int ID_COUNT = 65536
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  clre_pkg::clre_cmd_t    cmd_i,
  output clre_pkg::clre_status_t status_o,
  input  logic [2:0]             in_kind,
  input  logic [15:0]            in_station_id,
  input  logic [15:0]            in_new_id,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_neighbour_id
);
  import clre_pkg::*;

  localparam int AW = $clog2(ID_COUNT);

  // table entry of an id; the user must keep ID_COUNT a power of two, the block itself does not enforce it
  function automatic logic [AW-1:0] slot(input logic [15:0] id);
    return AW'(id);
  endfunction

  logic [15:0] next_mem [ID_COUNT];
  logic [15:0] prev_mem [ID_COUNT];

  logic [15:0]   next_q, prev_q;
  logic [AW-1:0] next_raddr, prev_raddr;
  logic [AW-1:0] next_waddr, prev_waddr;
  logic [15:0]   next_wdata, prev_wdata;
  logic          next_we, prev_we;

  logic [2:0]  kind_r;
  logic [15:0] station_r, new_r;
  logic [15:0] nx_hold_r, pv_hold_r, gone_r;
  logic [15:0] first_r, first_nxt, last_r, last_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_nbr_r;

  logic        after;
  logic [15:0] nbr_now, side_now;
  logic [15:0] sp_ins1, sn_ins1, sp_ins2, sn_ins2, sp_rem, sn_rem;

  assign after    = (kind_r == KIND_INS_AFTER) || (kind_r == KIND_REM_NEXT);
  assign nbr_now  = after ? next_q : prev_q;
  assign side_now = after ? next_q : prev_q;

  assign sp_ins1 = after ? station_r : prev_q;
  assign sn_ins1 = after ? next_q : station_r;
  assign sp_ins2 = after ? station_r : pv_hold_r;
  assign sn_ins2 = after ? nx_hold_r : station_r;
  assign sp_rem  = after ? station_r : side_now;
  assign sn_rem  = after ? side_now : station_r;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_INPUT: begin
        next_raddr = slot(in_station_id);
        prev_raddr = slot(in_station_id);
      end
      RD_LINK: begin
        next_raddr = slot(next_q);
        prev_raddr = slot(prev_q);
      end
      default: begin
        next_raddr = slot(station_r);
        prev_raddr = slot(station_r);
      end
    endcase
  end

  always_comb begin
    next_we      = 1'b0;
    prev_we      = 1'b0;
    next_waddr   = '0;
    prev_waddr   = '0;
    next_wdata   = '0;
    prev_wdata   = '0;
    first_nxt    = first_r;
    last_nxt     = last_r;
    nonempty_nxt = nonempty_r;
    case (cmd_i.wr_op)
      WR_AP_SOLO: begin
        next_we      = 1'b1;
        prev_we      = 1'b1;
        next_waddr   = slot(station_r);
        prev_waddr   = slot(station_r);
        next_wdata   = station_r;
        prev_wdata   = station_r;
        first_nxt    = station_r;
        last_nxt     = station_r;
        nonempty_nxt = 1'b1;
      end
      WR_AP_NEW: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = slot(station_r);
        prev_waddr = slot(station_r);
        next_wdata = first_r;
        prev_wdata = last_r;
      end
      WR_AP_ENDS: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = slot(last_r);
        prev_waddr = slot(first_r);
        next_wdata = station_r;
        prev_wdata = station_r;
        last_nxt   = station_r;
      end
      WR_INS_NEW: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = slot(new_r);
        prev_waddr = slot(new_r);
        next_wdata = sn_ins1;
        prev_wdata = sp_ins1;
      end
      WR_INS_SIDES: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = slot(sp_ins2);
        prev_waddr = slot(sn_ins2);
        next_wdata = new_r;
        prev_wdata = new_r;
      end
      WR_REM: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = slot(sp_rem);
        prev_waddr = slot(sn_rem);
        next_wdata = sn_rem;
        prev_wdata = sp_rem;
        if (gone_r == station_r) begin
          // the only id left the ring
          nonempty_nxt = 1'b0;
          first_nxt    = '0;
          last_nxt     = '0;
        end else begin
          if (gone_r == last_r) last_nxt = sp_rem;
          if (gone_r == first_r) first_nxt = sn_rem;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_q <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_q <= prev_mem[prev_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      kind_r    <= in_kind;
      station_r <= in_station_id;
      new_r     <= in_new_id;
    end
    if (cmd_i.load_out) begin
      nx_hold_r <= next_q;
      pv_hold_r <= prev_q;
      gone_r    <= nbr_now;
      out_nbr_r <= nbr_now;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd_i.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      last_r      <= '0;
      nonempty_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status_o.out_free      = !out_valid_r || !out_stall;
  assign status_o.ring_nonempty = nonempty_r;
  assign out_valid        = out_valid_r;
  assign out_neighbour_id = out_nbr_r;

endmodule

### src/clre_ctrl.sv
// controller state machine of the ring editor
// depends on clre_pkg and circular_linked_ring_editor_macros.svh; drives clre_dpath
module clre_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_kind,
  input  clre_pkg::clre_status_t status_i,
  output clre_pkg::clre_cmd_t    cmd_o
);
  import clre_pkg::*;
  `include "circular_linked_ring_editor_macros.svh"

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind) inside
            KIND_APPEND:                    state_nxt = S_AP1;
            KIND_INS_AFTER, KIND_INS_BEFORE: state_nxt = S_INS_EVAL;
            KIND_REM_NEXT, KIND_REM_PREV:   state_nxt = S_REM_EVAL;
            default:                        state_nxt = S_IDLE;
          endcase
        end
      end
      S_AP1:      state_nxt = status_i.ring_nonempty ? S_AP2 : S_IDLE;
      S_AP2:      state_nxt = S_IDLE;
      S_INS_EVAL: if (status_i.out_free) state_nxt = S_INS_W2;
      S_INS_W2:   state_nxt = S_IDLE;
      S_REM_EVAL: if (status_i.out_free) state_nxt = S_REM_WR;
      S_REM_WR:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.accept   = 1'b0;
    cmd_o.rd_sel   = RD_STATION;
    cmd_o.wr_op    = WR_NONE;
    cmd_o.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd_o.accept = in_valid;
        cmd_o.rd_sel = RD_INPUT;
      end
      S_AP1: cmd_o.wr_op = status_i.ring_nonempty ? WR_AP_NEW : WR_AP_SOLO;
      S_AP2: cmd_o.wr_op = WR_AP_ENDS;
      S_INS_EVAL: begin
        if (status_i.out_free) begin
          cmd_o.wr_op    = WR_INS_NEW;
          cmd_o.load_out = 1'b1;
        end
      end
      S_INS_W2: cmd_o.wr_op = WR_INS_SIDES;
      S_REM_EVAL: begin
        // second read follows the removed neighbour's link
        if (status_i.out_free) begin
          cmd_o.rd_sel   = RD_LINK;
          cmd_o.load_out = 1'b1;
        end
      end
      S_REM_WR: cmd_o.wr_op = WR_REM;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  `CLRE_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd_o.load_out, status_i.out_free)
  `CLRE_ASSERT_NEXT(a_insert_goes_eval, clk, rst_n,
    (state_r == S_IDLE) && in_valid &&
    ((in_kind == KIND_INS_AFTER) || (in_kind == KIND_INS_BEFORE)),
    state_r == S_INS_EVAL)
  `CLRE_ASSERT_NOW(a_remove_write_order, clk, rst_n, state_r == S_REM_WR,
    $past(state_r) == S_REM_EVAL)

endmodule

### src/circular_linked_ring_editor.sv
// channel   | ports                                          | direction
// in        | in_valid, in_stall, in_kind, in_station_id,    | item in
//           | in_new_id                                      |
// out       | out_valid, out_stall, out_neighbour_id         | result out
//
// an item is accepted in the idle state, which issues the first link read;
// write states follow for the single-port-write link memories, after the
// dependent read of a removal; kinds 5 to 7 are accepted and dropped
// inserts and removals wait in their read state while a result is held stalled
// reset is synchronous, active low; the link memories are not cleared
//
// top level of the ring editor; depends on clre_pkg, clre_ctrl, clre_dpath
module circular_linked_ring_editor #(
  parameter int ID_COUNT = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_station_id,
  input  logic [15:0] in_new_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_neighbour_id
);
  import clre_pkg::*;

  clre_cmd_t    cmd;
  clre_status_t status;

  clre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .status_i (status),
    .cmd_o    (cmd)
  );

  clre_dpath #(
    .ID_COUNT (ID_COUNT)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_kind          (in_kind),
    .in_station_id    (in_station_id),
    .in_new_id        (in_new_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_neighbour_id (out_neighbour_id)
  );

endmodule

### verif/tb_circular_linked_ring_editor.sv
// self-checking testbench for circular_linked_ring_editor: directed ring edits, then
// random edits under three idle mixes, each neighbour result checked against a local ring
// depends on clre_pkg and the circular_linked_ring_editor rtl
module tb_circular_linked_ring_editor;
  timeunit 1ns;
  timeprecision 1ps;
  import clre_pkg::*;

  localparam int ID_COUNT        = 65536;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = 16;
  localparam int WALK_MAX        = 64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] station;
    logic [15:0] fresh;
  } edit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = KIND_APPEND;
  logic [15:0] in_station_id = 16'h0000;
  logic [15:0] in_new_id = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_neighbour_id;

  circular_linked_ring_editor #(
    .ID_COUNT(ID_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_station_id(in_station_id),
    .in_new_id(in_new_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_neighbour_id(out_neighbour_id)
  );

  // local copy of the ring
  logic [15:0] next_tab [ID_COUNT];
  logic [15:0] prev_tab [ID_COUNT];
  logic [15:0] head_id = 16'h0000;
  logic [15:0] tail_id = 16'h0000;
  logic        ring_live = 1'b0;

  logic [15:0] neighbour_q [$];
  edit_t       pending_q [$];
  logic [15:0] ring_ids [$];

  int issued_count = 0;
  int sent_count = 0;
  int taken_count = 0;
  int results_seen = 0;
  int err_count = 0;
  int app_hits = 0;
  int ins_hits = 0;
  int rem_hits = 0;
  int skip_hits = 0;
  int phase = 1;
  int send_idle_pct = 36;
  int recv_idle_pct = 58;
  logic hold_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int slot(logic [15:0] id);
    return int'(id) % ID_COUNT;
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  // applies one accepted edit to the local ring and queues the neighbour result of an insert or removal
  function automatic void apply_edit(logic [2:0] kind, logic [15:0] sid, logic [15:0] nid);
    logic [15:0] nx, pv, side_prev, side_next, gone;
    logic        after;
    if (kind == KIND_APPEND) begin
      app_hits++;
      if (!ring_live) begin
        next_tab[slot(sid)] = sid;
        prev_tab[slot(sid)] = sid;
        head_id = sid;
        tail_id = sid;
        ring_live = 1'b1;
      end else begin
        prev_tab[slot(sid)] = tail_id;
        next_tab[slot(sid)] = head_id;
        next_tab[slot(tail_id)] = sid;
        prev_tab[slot(head_id)] = sid;
        tail_id = sid;
      end
    end else if (kind > KIND_REM_PREV) begin
      skip_hits++;
    end else begin
      nx = next_tab[slot(sid)];
      pv = prev_tab[slot(sid)];
      after = (kind == KIND_INS_AFTER) || (kind == KIND_REM_NEXT);
      neighbour_q.push_back(after ? nx : pv);
      if (kind == KIND_INS_AFTER || kind == KIND_INS_BEFORE) begin
        ins_hits++;
        side_prev = after ? sid : pv;
        side_next = after ? nx : sid;
        // write order matters when new_id aliases a ring member
        next_tab[slot(nid)] = side_next;
        prev_tab[slot(nid)] = side_prev;
        next_tab[slot(side_prev)] = nid;
        prev_tab[slot(side_next)] = nid;
      end else begin
        rem_hits++;
        gone = after ? nx : pv;
        side_prev = after ? sid : prev_tab[slot(pv)];
        side_next = after ? next_tab[slot(nx)] : sid;
        next_tab[slot(side_prev)] = side_next;
        prev_tab[slot(side_next)] = side_prev;
        if (gone == sid) begin
          ring_live = 1'b0;
          head_id = 16'h0000;
          tail_id = 16'h0000;
        end else begin
          if (gone == tail_id) tail_id = side_prev;
          if (gone == head_id) head_id = side_next;
        end
      end
    end
  endfunction

  function automatic void offer(logic [2:0] kind, logic [15:0] sid, logic [15:0] nid);
    edit_t it;
    it.kind = kind;
    it.station = sid;
    it.fresh = nid;
    pending_q.push_back(it);
    issued_count++;
  endfunction

  // an id not on the walked ring; small ids come back often so stale links get reused
  function automatic logic [15:0] pick_fresh_id();
    logic [15:0] cand;
    bit          clash;
    do begin
      case ($urandom_range(9))
        0, 1: cand = 16'($urandom_range(32, 1));
        2: begin
          case ($urandom_range(3))
            0: cand = 16'h0001;
            1: cand = 16'h7FFF;
            2: cand = 16'h8000;
            default: cand = 16'hFFFF;
          endcase
        end
        default: cand = 16'($urandom_range(65535, 1));
      endcase
      clash = 1'b0;
      foreach (ring_ids[i])
        if (ring_ids[i] == cand) clash = 1'b1;
    end while (clash);
    return cand;
  endfunction

  // one random edit from the current ring; returns 0 for an ignored kind
  function automatic bit random_edit();
    logic [15:0] walk;
    logic [2:0]  kind;
    logic [15:0] sid, nid;
    int          w_app, w_ins, roll;
    ring_ids.delete();
    if (ring_live) begin
      walk = head_id;
      for (int i = 0; i < WALK_MAX; i++) begin
        ring_ids.push_back(walk);
        walk = next_tab[slot(walk)];
        if (walk == head_id) break;
      end
    end
    if ($urandom_range(99) < 5) begin
      offer(KIND_REM_PREV + 3'($urandom_range(3, 1)), 16'($urandom_range(65535, 1)),
            16'($urandom_range(65535)));
      return 1'b0;
    end
    // keep the ring between a few and a couple dozen ids
    if (ring_ids.size() < 3) begin
      w_app = 40;
      w_ins = 50;
    end else if (ring_ids.size() > 24) begin
      w_app = 5;
      w_ins = 15;
    end else begin
      w_app = 20;
      w_ins = 40;
    end
    roll = $urandom_range(99);
    if (!ring_live || roll < w_app) begin
      offer(KIND_APPEND, pick_fresh_id(), 16'($urandom_range(65535)));
    end else begin
      sid = ring_ids[$urandom_range(ring_ids.size() - 1)];
      if (roll < w_app + w_ins) begin
        kind = $urandom_range(1) ? KIND_INS_AFTER : KIND_INS_BEFORE;
        nid = pick_fresh_id();
      end else begin
        kind = $urandom_range(1) ? KIND_REM_NEXT : KIND_REM_PREV;
        nid = 16'($urandom_range(65535));
      end
      offer(kind, sid, nid);
    end
    return 1'b1;
  endfunction

  always @(negedge clk) begin : driver
    edit_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken_count == sent_count) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_q.pop_front();
        in_kind <= it.kind;
        in_station_id <= it.station;
        in_new_id <= it.fresh;
        in_valid <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    logic [15:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (neighbour_q.size() == 0) begin
          flag_mismatch("result with nothing pending", out_neighbour_id, 16'h0000);
        end else begin
          want = neighbour_q.pop_front();
          results_seen++;
          if (out_neighbour_id !== want)
            flag_mismatch("out_neighbour_id", out_neighbour_id, want);
        end
      end
      if (in_valid && !in_stall) begin
        apply_edit(in_kind, in_station_id, in_new_id);
        taken_count++;
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (phase == 3);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  initial begin : stimulus
    int done_here;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // single id ring, then removed again
    offer(KIND_APPEND, 16'hFFFF, 16'h0000);
    offer(KIND_REM_PREV, 16'hFFFF, 16'hFFFF);
    offer(KIND_APPEND, 16'h0001, 16'hFFFF);
    offer(KIND_APPEND, 16'hFFFF, 16'h0000);
    offer(KIND_APPEND, 16'h5555, 16'hAAAA);
    offer(KIND_APPEND, 16'hAAAA, 16'h5555);
    offer(KIND_INS_AFTER, 16'h0001, 16'h1234);
    offer(KIND_INS_BEFORE, 16'h0001, 16'hFFFE);
    offer(KIND_REM_NEXT, 16'hAAAA, 16'h0000);
    // removals that move the head and the tail
    offer(KIND_REM_PREV, 16'h1234, 16'hFFFF);
    offer(KIND_REM_NEXT, 16'h5555, 16'h0000);
    offer(KIND_REM_PREV, 16'h1234, 16'h8000);
    offer(KIND_REM_PREV + 3'd1, 16'h1234, 16'hFFFF);
    offer(KIND_REM_PREV + 3'd2, 16'hFFFF, 16'h0000);
    offer(KIND_REM_PREV + 3'd3, 16'h0001, 16'h7FFF);
    // new id already on the ring, then new id equal to the station
    offer(KIND_INS_AFTER, 16'hFFFF, 16'h1234);
    offer(KIND_INS_BEFORE, 16'hFFFF, 16'hFFFF);
    // self loop left behind, so this empties the ring
    offer(KIND_REM_NEXT, 16'hFFFF, 16'h0000);

    for (int p = 1; p <= 3; p++) begin
      phase = p;
      send_idle_pct = (p == 1) ? 36 : (p == 2) ? 58 : 0;
      recv_idle_pct = (p == 1) ? 58 : (p == 2) ? 36 : 0;
      done_here = 0;
      while (done_here < ITEMS_PER_PHASE) begin
        // next edit is drawn from the ring after every earlier transfer
        while (taken_count != issued_count) begin
          @(posedge clk);
          #1;
        end
        if (random_edit()) done_here++;
      end
    end

    while (taken_count != issued_count || neighbour_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    $display("covered %0d appends, %0d inserts, %0d removals, %0d ignored kinds",
             app_hits, ins_hits, rem_hits, skip_hits);
    $display("checked %0d neighbour results over three idle mixes and a %0d-cycle hold-off",
             results_seen, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("timeout with %0d results still pending", neighbour_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
